>>> hdl/afpe_pkg.sv
// shared types, constants and codes for the api frame payload extractor
// no dependencies; imported by afpe_parser and the top level
package afpe_pkg;

    // default depth of the frame data memory
    localparam int FRAME_STORE_DEPTH_DEF = 256;

    // frame format constants
    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [7:0] TYPE_RX64     = 8'h80;
    localparam logic [7:0] TYPE_RX16     = 8'h81;
    localparam int         DATA_OFF64    = 11;
    localparam int         DATA_OFF16    = 5;
    localparam int         RSSI_IDX64    = 9;
    localparam int         RSSI_IDX16    = 3;
    localparam logic [5:0] MAX_PAYLOAD   = 6'd62;

    // configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam int         CFG_DATA_W         = 8;
    localparam logic [1:0] CFG_PAYLOAD_LENGTH = 2'd0;
    localparam logic [1:0] CFG_START_MARKER   = 2'd1;
    localparam logic [1:0] CFG_END_MARKER     = 2'd2;

    // configuration reset values
    localparam logic [5:0] RST_PAYLOAD_LENGTH = 6'd62;
    localparam logic [7:0] RST_START_MARKER   = 8'hAA;
    localparam logic [7:0] RST_END_MARKER     = 8'h55;

    // result status codes
    localparam logic [2:0] ST_PAYLOAD   = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_CSUM_BAD  = 3'd2;
    localparam logic [2:0] ST_OTHER     = 3'd3;
    localparam logic [2:0] ST_NO_MARKER = 3'd4;
    localparam logic [2:0] ST_END_BAD   = 3'd5;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // byte parser phases
    typedef enum logic [4:0] {
        P_HUNT   = 5'b00001,
        P_LEN_HI = 5'b00010,
        P_LEN_LO = 5'b00100,
        P_DATA   = 5'b01000,
        P_CSUM   = 5'b10000
    } t_phase;

    // payload drain sequencer states
    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_END  = 4'b0010,
        D_RD   = 4'b0100,
        D_OUT  = 4'b1000
    } t_drain_state;

    // frame summary handed from the parser to the top level
    typedef struct packed {
        logic [15:0] frame_length;
        logic [7:0]  running_sum;
        logic        marker_seen;
        logic        type_ok;
        logic        address_mode;
        logic [7:0]  rssi;
    } t_frame_info;

    // one result item
    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        payload_byte;
        logic [5:0]        payload_index;
        logic signed [8:0] rssi_dbm;
        logic              address_mode;
        logic              last;
    } t_result;

endpackage

>>> hdl/afpe_frame_ram.sv
// frame data memory: one write port, one read port, registered read data
// depends on nothing but its parameters
module afpe_frame_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/afpe_parser.sv
// byte-level frame parser: start hunt, length, checksum sum, type, rssi, marker search
// depends on afpe_pkg; drives the write port of afpe_frame_ram
module afpe_parser #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_start_marker,
    output afpe_pkg::t_phase     o_phase,
    output logic                 o_too_long,
    output afpe_pkg::t_frame_info o_info,
    output logic [AW-1:0]        o_marker_pos,
    output logic                 o_mem_we,
    output logic [AW-1:0]        o_mem_waddr
);
    import afpe_pkg::*;

    localparam logic [16:0] MaxLen = 17'(DEPTH - 3);

    t_phase      r_phase,  n_phase;
    logic [15:0] r_flen,   n_flen;
    logic [AW-1:0] r_bt,   n_bt;
    logic [7:0]  r_sum,    n_sum;
    logic        r_seen,   n_seen;
    logic [AW-1:0] r_mpos, n_mpos;
    logic        r_type_ok, n_type_ok;
    logic        r_mode,   n_mode;
    logic [7:0]  r_rssi,   n_rssi;

    logic [15:0]   len_now;
    logic [AW-1:0] off, ridx;
    logic [16:0]   bt_next;

    assign len_now    = {r_flen[15:8], i_byte};
    assign o_too_long = ({1'b0, len_now} > MaxLen);
    assign off        = r_mode ? AW'(DATA_OFF16) : AW'(DATA_OFF64);
    assign ridx       = r_mode ? AW'(RSSI_IDX16) : AW'(RSSI_IDX64);
    assign bt_next    = 17'(r_bt) + 17'd1;

    always_comb begin
        n_phase   = r_phase;
        n_flen    = r_flen;
        n_bt      = r_bt;
        n_sum     = r_sum;
        n_seen    = r_seen;
        n_mpos    = r_mpos;
        n_type_ok = r_type_ok;
        n_mode    = r_mode;
        n_rssi    = r_rssi;
        if (i_take) begin
            unique case (r_phase)
                P_HUNT: begin
                    if (i_byte == START_BYTE) begin
                        n_phase = P_LEN_HI;
                    end
                end
                P_LEN_HI: begin
                    n_flen  = {i_byte, 8'h00};
                    n_phase = P_LEN_LO;
                end
                P_LEN_LO: begin
                    n_flen = len_now;
                    n_bt   = '0;
                    n_sum  = '0;
                    n_seen = 1'b0;
                    n_mpos = '0;
                    n_rssi = '0;
                    if (o_too_long) begin
                        n_phase = P_HUNT;
                    end else if (len_now == 16'd0) begin
                        n_phase = P_CSUM;
                    end else begin
                        n_phase = P_DATA;
                    end
                end
                P_DATA: begin
                    n_sum = r_sum + i_byte;
                    if (r_bt == '0) begin
                        // first data byte is the frame type
                        n_type_ok = (i_byte == TYPE_RX64) || (i_byte == TYPE_RX16);
                        n_mode    = (i_byte == TYPE_RX16);
                    end else if (r_type_ok) begin
                        if (r_bt == ridx) begin
                            n_rssi = i_byte;
                        end
                        // first start marker at or after the data offset, not the last byte
                        if (!r_seen && r_bt >= off && bt_next < {1'b0, r_flen}
                            && i_byte == i_start_marker) begin
                            n_seen = 1'b1;
                            n_mpos = r_bt;
                        end
                    end
                    n_bt = AW'(bt_next);
                    if (bt_next >= {1'b0, r_flen}) begin
                        n_phase = P_CSUM;
                    end
                end
                P_CSUM: begin
                    n_phase = P_HUNT;
                end
                default: begin
                    n_phase = P_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_HUNT;
            r_flen    <= '0;
            r_bt      <= '0;
            r_sum     <= '0;
            r_seen    <= 1'b0;
            r_mpos    <= '0;
            r_type_ok <= 1'b0;
            r_mode    <= 1'b0;
            r_rssi    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_flen    <= n_flen;
            r_bt      <= n_bt;
            r_sum     <= n_sum;
            r_seen    <= n_seen;
            r_mpos    <= n_mpos;
            r_type_ok <= n_type_ok;
            r_mode    <= n_mode;
            r_rssi    <= n_rssi;
        end
    end

    assign o_phase      = r_phase;
    assign o_marker_pos = r_mpos;
    assign o_mem_we     = i_take && (r_phase == P_DATA);
    assign o_mem_waddr  = r_bt;

    always_comb begin
        o_info              = '0;
        o_info.frame_length = r_flen;
        o_info.running_sum  = r_sum;
        o_info.marker_seen  = r_seen;
        o_info.type_ok      = r_type_ok;
        o_info.address_mode = r_mode;
        o_info.rssi         = r_rssi;
    end

endmodule

>>> hdl/api_frame_payload_extractor_core.sv
// top level of the api frame payload extractor: config registers, frame checks,
// payload drain sequencer and result register; uses afpe_pkg, afpe_parser, afpe_frame_ram
//
//  channel   dir  signals                          carries
//  s_axis    in   i_s_axis_tvalid/tready/tdata     rx_byte, one per transfer
//  m_axis    out  o_m_axis_tvalid/tready/tdata/tlast  one result per transfer
//  cfg       in   i_cfg_we/i_cfg_addr/i_cfg_wdata  register writes, no read-back
//
// one received byte is taken per cycle while the frame header and data arrive,
// unless the length low byte waits on a busy result register; after the
// checksum byte, the end marker is read from the frame memory, then each payload
// byte is a memory read, then a result register load; the frame memory has a
// single read port, and no byte is taken while the payload drains
// the length low byte and checksum byte wait on a free result register; reset is
// synchronous, active low, and needs no clearing pass of the frame memory
module api_frame_payload_extractor_core
    import afpe_pkg::*;
#(
    parameter int FRAME_STORE_DEPTH = afpe_pkg::FRAME_STORE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // rx stream: [7:0] rx_byte
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [afpe_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // result stream: [2:0] status, [10:3] payload_byte, [16:11] payload_index,
    // [25:17] rssi_dbm, [26] address_mode, [31:27] zero
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [afpe_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [afpe_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [afpe_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW = $clog2(FRAME_STORE_DEPTH);

    // configuration registers
    logic [5:0] r_pay_len;
    logic [7:0] r_start_mk;
    logic [7:0] r_end_mk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay_len  <= RST_PAYLOAD_LENGTH;
            r_start_mk <= RST_START_MARKER;
            r_end_mk   <= RST_END_MARKER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PAYLOAD_LENGTH: r_pay_len  <= i_cfg_wdata[5:0];
                CFG_START_MARKER:   r_start_mk <= i_cfg_wdata;
                CFG_END_MARKER:     r_end_mk   <= i_cfg_wdata;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // effective payload length: zero acts as one, capped at the maximum
    logic [5:0] len_eff;
    always_comb begin
        if (r_pay_len == 6'd0) begin
            len_eff = 6'd1;
        end else if (r_pay_len > MAX_PAYLOAD) begin
            len_eff = MAX_PAYLOAD;
        end else begin
            len_eff = r_pay_len;
        end
    end

    // result register
    t_result r_out, n_out;
    logic    r_out_vld, n_out_vld;
    logic    out_free;
    assign out_free = !r_out_vld || i_m_axis_tready;

    // drain sequencer
    t_drain_state r_dst, n_dst;
    logic [5:0]   r_idx, n_idx;

    // parser
    t_phase       phase;
    logic         too_long;
    t_frame_info  info;
    logic [AW-1:0] mpos;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic         take;
    logic         needs_out;
    logic [7:0]   rx_byte;

    assign rx_byte         = i_s_axis_tdata[7:0];
    // length low byte and checksum byte may produce a result
    assign needs_out       = (phase == P_LEN_LO) || (phase == P_CSUM);
    assign o_s_axis_tready = (r_dst == D_IDLE) && (!needs_out || out_free);
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    afpe_parser #(
        .DEPTH (FRAME_STORE_DEPTH),
        .AW    (AW)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_byte         (rx_byte),
        .i_start_marker (r_start_mk),
        .o_phase        (phase),
        .o_too_long     (too_long),
        .o_info         (info),
        .o_marker_pos   (mpos),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr)
    );

    // frame memory read side
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] len_aw;
    logic [AW-1:0] end_addr;
    logic [AW-1:0] pay_addr;

    assign len_aw   = {{(AW-6){1'b0}}, len_eff};
    // end marker sits right behind the payload; no wrap since it lies inside the frame
    assign end_addr = mpos + len_aw + AW'(1);
    assign pay_addr = mpos + AW'(1) + {{(AW-6){1'b0}}, r_idx};

    afpe_frame_ram #(
        .DEPTH (FRAME_STORE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (rx_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // checks made as the checksum byte arrives
    logic              csum_take;
    logic              sum_bad;
    logic              other_type;
    logic              too_short;
    logic signed [8:0] rssi_neg;
    logic [15:0]       room;

    assign csum_take  = take && (phase == P_CSUM);
    assign sum_bad    = (~info.running_sum) != rx_byte;
    assign other_type = (info.frame_length == 16'd0) || !info.type_ok;
    assign room       = info.frame_length - 16'(mpos);
    assign too_short  = !info.marker_seen || (room < (16'(len_eff) + 16'd2));
    assign rssi_neg   = 9'sd0 - $signed({1'b0, info.rssi});

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_dst     = r_dst;
        n_idx     = r_idx;
        mem_re    = 1'b0;
        mem_raddr = pay_addr;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_dst)
            D_IDLE: begin
                if (take && phase == P_LEN_LO && too_long) begin
                    n_out        = '0;
                    n_out.status = ST_TOO_LONG;
                    n_out.last   = 1'b1;
                    n_out_vld    = 1'b1;
                end else if (csum_take) begin
                    n_out      = '0;
                    n_out.last = 1'b1;
                    if (sum_bad) begin
                        n_out.status = ST_CSUM_BAD;
                        n_out_vld    = 1'b1;
                    end else if (other_type) begin
                        n_out.status = ST_OTHER;
                        n_out_vld    = 1'b1;
                    end else if (too_short) begin
                        n_out.status       = ST_NO_MARKER;
                        n_out.rssi_dbm     = rssi_neg;
                        n_out.address_mode = info.address_mode;
                        n_out_vld          = 1'b1;
                    end else begin
                        // fetch the end marker
                        mem_re    = 1'b1;
                        mem_raddr = end_addr;
                        n_idx     = '0;
                        n_dst     = D_END;
                    end
                end
            end
            D_END: begin
                if (mem_rdata != r_end_mk) begin
                    if (out_free) begin
                        n_out              = '0;
                        n_out.status       = ST_END_BAD;
                        n_out.rssi_dbm     = rssi_neg;
                        n_out.address_mode = info.address_mode;
                        n_out.last         = 1'b1;
                        n_out_vld          = 1'b1;
                        n_dst              = D_IDLE;
                    end
                end else begin
                    n_dst = D_RD;
                end
            end
            D_RD: begin
                mem_re = 1'b1;
                n_dst  = D_OUT;
            end
            D_OUT: begin
                // read data holds until the next read
                if (out_free) begin
                    n_out.status        = ST_PAYLOAD;
                    n_out.payload_byte  = mem_rdata;
                    n_out.payload_index = r_idx;
                    n_out.rssi_dbm      = rssi_neg;
                    n_out.address_mode  = info.address_mode;
                    n_out.last          = (6'(r_idx + 6'd1) == len_eff);
                    n_out_vld           = 1'b1;
                    n_idx               = 6'(r_idx + 6'd1);
                    n_dst               = (6'(r_idx + 6'd1) == len_eff) ? D_IDLE : D_RD;
                end
            end
            default: begin
                n_dst = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_dst     <= D_IDLE;
            r_idx     <= '0;
        end else begin
            r_out_vld <= n_out_vld;
            r_dst     <= n_dst;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {5'd0, r_out.address_mode, r_out.rssi_dbm,
                              r_out.payload_index, r_out.payload_byte, r_out.status};

endmodule
